// ----- hdl/ptd_pkg.sv -----
// Shared types and constants of the periodic task dispatcher.
package ptd_pkg;

  localparam int TASK_COUNT = 8;
  localparam int IDX_W      = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int FUNC_W     = 3;
  localparam int TASK_W     = 3;
  localparam int TIME_W     = 16;

  typedef enum logic [FUNC_W-1:0] {
    FN_CREATE  = 3'd0,
    FN_SUSPEND = 3'd1,
    FN_RESUME  = 3'd2,
    FN_DELETE  = 3'd3,
    FN_TICK    = 3'd4
  } func_e;

  // Input word: one command or one tick
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] first_delay;
  } in_word_t;

  // Output word: one due task
  typedef struct packed {
    logic [TASK_W-1:0] run_task;
    logic              last_run;
  } out_word_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] first_delay;
  } cell_cmd_t;

  // Status of the cell chain seen by the controller
  typedef struct packed {
    logic active;
    logic hit;
    logic tail;
  } scan_stat_t;

  // Controls from the controller to the chain
  typedef struct packed {
    logic start;
    logic shift;
  } scan_ctrl_t;

endpackage

// ----- hdl/ptd_cell.sv -----
// One task slot of the dispatcher chain, with its share of the scan token.
module ptd_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptd_pkg::cell_cmd_t   cmd_i,
  input  logic                 sel_i,
  input  logic                 shift_i,
  input  logic                 token_i,
  output logic                 token_o,
  output logic                 hit_o
);

  logic                        valid_q, valid_d;
  logic                        susp_q, susp_d;
  logic                        token_q;
  logic [ptd_pkg::TIME_W-1:0]  period_q, period_d;
  logic [ptd_pkg::TIME_W-1:0]  count_q, count_d;
  logic                        visit;

  assign visit   = token_q && valid_q && !susp_q;
  assign hit_o   = visit && (count_q == '0);
  assign token_o = token_q;

  // Apply a command, or count down (reloading at zero) when the scan token passes
  always_comb begin
    valid_d  = valid_q;
    susp_d   = susp_q;
    period_d = period_q;
    count_d  = count_q;
    if (sel_i) begin
      unique case (ptd_pkg::func_e'(cmd_i.func))
        ptd_pkg::FN_CREATE: begin
          if (!valid_q) begin
            valid_d  = 1'b1;
            susp_d   = 1'b0;
            period_d = cmd_i.period;
            count_d  = cmd_i.first_delay;
          end
        end
        ptd_pkg::FN_SUSPEND: susp_d  = 1'b1;
        ptd_pkg::FN_RESUME:  susp_d  = 1'b0;
        ptd_pkg::FN_DELETE:  valid_d = 1'b0;
        default: ;
      endcase
    end else if (shift_i && visit) begin
      if (count_q == '0) begin
        count_d = period_q - ptd_pkg::TIME_W'(1);
      end else begin
        count_d = count_q - ptd_pkg::TIME_W'(1);
      end
    end
  end

  // Hold slot flags and the token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      susp_q  <= 1'b0;
      token_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      susp_q  <= susp_d;
      if (shift_i) begin
        token_q <= token_i;
      end
    end
  end

  // Hold period and countdown
  always_ff @(posedge clk_i) begin
    period_q <= period_d;
    count_q  <= count_d;
  end

endmodule

// ----- hdl/ptd_ctrl.sv -----
// Scan controller: steps the token, holds one due task back and drives the output word.
module ptd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tick_i,
  input  ptd_pkg::scan_stat_t  stat_i,
  output ptd_pkg::scan_ctrl_t  ctrl_o,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ptd_pkg::out_word_t   out_word_o
);

  logic [ptd_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic [ptd_pkg::IDX_W-1:0]   hold_idx_q, hold_idx_d;
  logic                        hold_v_q, hold_v_d;
  logic                        finish_q, finish_d;
  logic                        out_v_q, out_v_d;
  ptd_pkg::out_word_t          out_q, out_d;
  logic                        out_free;
  logic                        step_ok;
  logic                        shift;

  assign out_free = !out_v_q || !out_stall_i;
  assign busy_o   = stat_i.active || finish_q || hold_v_q;
  assign step_ok  = stat_i.active && (!stat_i.hit || !hold_v_q || out_free);
  assign shift    = tick_i || step_ok;

  assign ctrl_o.start = tick_i;
  assign ctrl_o.shift = shift;
  assign out_valid_o  = out_v_q;
  assign out_word_o   = out_q;

  // Advance the scan, park each due task until the next one or the end
  always_comb begin
    idx_d      = idx_q;
    hold_idx_d = hold_idx_q;
    hold_v_d   = hold_v_q;
    finish_d   = finish_q;
    out_v_d    = out_v_q && out_stall_i;
    out_d      = out_q;
    if (tick_i) begin
      idx_d = '0;
    end else if (step_ok) begin
      idx_d = idx_q + ptd_pkg::IDX_W'(1);
      if (stat_i.tail) begin
        finish_d = 1'b1;
      end
      if (stat_i.hit) begin
        if (hold_v_q) begin
          out_v_d          = 1'b1;
          out_d.run_task   = ptd_pkg::TASK_W'(hold_idx_q);
          out_d.last_run   = 1'b0;
        end
        hold_v_d   = 1'b1;
        hold_idx_d = idx_q;
      end
    end else if (finish_q) begin
      if (!hold_v_q) begin
        finish_d = 1'b0;
      end else if (out_free) begin
        out_v_d        = 1'b1;
        out_d.run_task = ptd_pkg::TASK_W'(hold_idx_q);
        out_d.last_run = 1'b1;
        hold_v_d       = 1'b0;
        finish_d       = 1'b0;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      hold_v_q <= 1'b0;
      finish_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      hold_v_q <= hold_v_d;
      finish_q <= finish_d;
      out_v_q  <= out_v_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    hold_idx_q <= hold_idx_d;
    out_q      <= out_d;
  end

endmodule

// ----- hdl/periodic_task_dispatcher_top.sv -----
// Top level of the periodic task dispatcher: the chain of slot cells and its controller.
//
// Input channel (in_valid_i, in_stall_o, in_word_i) takes one word per command:
// create, suspend, resume and delete act on one slot when taken, producing no
// output. A tick word starts a scan: a token walks down the row of slot cells,
// one cell per cycle unless a stalled receiver holds it, and a finish step then
// flushes the last due word.
// Every ready slot counts down; a slot at zero reloads and is reported as due.
// Output channel (out_valid_o, out_stall_i, out_word_o) gives one word per due
// task in slot order, with last_run set on the final one of the tick. The first
// due word appears once the next due slot or the end of the row is reached.
// The input stays stalled while a tick is being scanned; commands may be sent
// while the last output word still waits. A stalled receiver halts the token
// only when a due word cannot be parked; the output word holds until taken.
// Reset empties all slots, clears the scan and drops any pending output word.
module periodic_task_dispatcher_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ptd_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ptd_pkg::out_word_t  out_word_o
);

  ptd_pkg::cell_cmd_t                 cmd;
  ptd_pkg::scan_stat_t                stat;
  ptd_pkg::scan_ctrl_t                ctrl;
  logic                               busy;
  logic                               take;
  logic                               is_tick;
  logic [ptd_pkg::TASK_COUNT:0]       token;
  logic [ptd_pkg::TASK_COUNT-1:0]     hit;

  assign in_stall_o = busy;
  assign take       = in_valid_i && !busy;
  assign is_tick    = (in_word_i.func == ptd_pkg::FN_TICK);

  assign cmd.func        = in_word_i.func;
  assign cmd.period      = in_word_i.period;
  assign cmd.first_delay = in_word_i.first_delay;

  assign token[0]    = ctrl.start;
  assign stat.active = |token[ptd_pkg::TASK_COUNT:1];
  assign stat.hit    = |hit;
  assign stat.tail   = token[ptd_pkg::TASK_COUNT];

  // Row of slot cells, token handed from each to the next
  for (genvar i = 0; i < ptd_pkg::TASK_COUNT; i++) begin : g_cell
    logic sel;
    assign sel = take && !is_tick && (int'(in_word_i.task_id) == i);

    ptd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .sel_i   (sel),
      .shift_i (ctrl.shift),
      .token_i (token[i]),
      .token_o (token[i+1]),
      .hit_o   (hit[i])
    );
  end

  ptd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (take && is_tick),
    .stat_i      (stat),
    .ctrl_o      (ctrl),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
